@@ design/obpl_pkg.sv @@
// ============================================================================
// obpl_pkg
// Shared types, constants and scan helpers for the price level tracker.
// ============================================================================
`default_nettype none

package obpl_pkg;

    // Level array geometry (LEVELS a power of two, at least 64)
    localparam int LEVELS     = 1024;
    localparam int IDX_W      = $clog2(LEVELS);
    localparam int WORD_W     = 32;
    localparam int COL_W      = $clog2(WORD_W);
    localparam int ROWS       = LEVELS / WORD_W;
    localparam int ROW_W      = IDX_W - COL_W;
    localparam int USED_W     = IDX_W + 1;
    localparam int SCAN_W     = (WORD_W > ROWS) ? WORD_W : ROWS;
    localparam int SCAN_IDX_W = $clog2(SCAN_W);

    // Field widths
    localparam int KIND_W   = 2;
    localparam int PRICE_W  = 32;
    localparam int SLOT_W   = 16;
    localparam int HEAD_W   = 17;
    localparam int CNT_W    = 11;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 32;

    // Head or tail value reported for an inactive level
    localparam logic [HEAD_W-1:0] ORDER_SLOTS = HEAD_W'(65536);

    // Item kinds
    localparam logic [KIND_W-1:0] KIND_ACTIVATE   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_DEACTIVATE = 2'd1;
    localparam logic [KIND_W-1:0] KIND_LOOKUP     = 2'd2;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_IS_BID      = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_PRICE   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LEVEL_COUNT = 2'd2;

    // Request from the controller to the level store
    typedef struct packed {
        logic                 rd_en;
        logic [IDX_W-1:0]     rd_idx;
        logic                 wr_en;
        logic [IDX_W-1:0]     wr_idx;
        logic [WORD_W-1:0]    wr_word;
        logic                 wr_slot_en;
        logic [SLOT_W-1:0]    wr_slot;
    } store_req_t;

    // Read data returned by the level store
    typedef struct packed {
        logic [WORD_W-1:0]    word;
        logic [SLOT_W-1:0]    head;
        logic [SLOT_W-1:0]    tail;
        logic [ROWS-1:0]      summary;
    } store_rsp_t;

    typedef struct packed {
        logic                  found;
        logic [SCAN_IDX_W-1:0] pos;
    } hit_t;

    // Highest set bit
    function automatic hit_t find_high(input logic [SCAN_W-1:0] v);
        hit_t h;
        h.found = 1'b0;
        h.pos   = '0;
        for (int j = 0; j < SCAN_W; j++) begin
            if (v[j]) begin
                h.found = 1'b1;
                h.pos   = SCAN_IDX_W'(j);
            end
        end
        return h;
    endfunction

    // Lowest set bit
    function automatic hit_t find_low(input logic [SCAN_W-1:0] v);
        hit_t h;
        h.found = 1'b0;
        h.pos   = '0;
        for (int j = SCAN_W - 1; j >= 0; j--) begin
            if (v[j]) begin
                h.found = 1'b1;
                h.pos   = SCAN_IDX_W'(j);
            end
        end
        return h;
    endfunction

endpackage

`default_nettype wire

@@ design/obpl_if.sv @@
// ============================================================================
// obpl_if
// Valid/ready channels for request items and result items.
// ============================================================================
`default_nettype none

interface obpl_req_if;
    logic               valid;
    logic               ready;
    logic [1:0]         kind;
    logic signed [31:0] price;
    logic [15:0]        order_index;

    modport source (output valid, kind, price, order_index, input ready);
    modport sink   (input valid, kind, price, order_index, output ready);
endinterface

interface obpl_rsp_if;
    logic               valid;
    logic               ready;
    logic               status;
    logic               level_active;
    logic [16:0]        level_head;
    logic [16:0]        level_tail;
    logic               best_valid;
    logic signed [31:0] best_price;

    modport source (output valid, status, level_active, level_head, level_tail,
                    best_valid, best_price, input ready);
    modport sink   (input valid, status, level_active, level_head, level_tail,
                    best_valid, best_price, output ready);
endinterface

`default_nettype wire

@@ design/obpl_level_store.sv @@
// ============================================================================
// obpl_level_store
// Active bitmap in rows of WORD_W bits, one summary flop per row, and the
// head/tail slot memory. Read data is registered.
// ============================================================================
`default_nettype none

module obpl_level_store
    import obpl_pkg::*;
(
    input  wire        clk,
    input  wire        rst_n,
    input  store_req_t req,
    output store_rsp_t rsp
);

    logic [WORD_W-1:0]   row_mem  [ROWS];
    logic [2*SLOT_W-1:0] slot_mem [LEVELS];

    logic [ROWS-1:0]     summary_reg;
    logic                row_valid_reg;
    logic [WORD_W-1:0]   word_q_reg;
    logic [2*SLOT_W-1:0] slot_q_reg;

    logic [ROW_W-1:0]    rd_row;
    logic [ROW_W-1:0]    wr_row;

    assign rd_row = req.rd_idx[IDX_W-1:COL_W];
    assign wr_row = req.wr_idx[IDX_W-1:COL_W];

    // Bitmap rows and slot entries
    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            row_mem[wr_row] <= req.wr_word;
        end
        if (req.wr_slot_en)
        begin
            slot_mem[req.wr_idx] <= {req.wr_slot, req.wr_slot};
        end
        if (req.rd_en)
        begin
            word_q_reg <= row_mem[rd_row];
            slot_q_reg <= slot_mem[req.rd_idx];
        end
    end

    // Row summary: a clear flop means the row reads as all zero
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            summary_reg   <= '0;
            row_valid_reg <= 1'b0;
        end
        else
        begin
            if (req.wr_en)
            begin
                summary_reg[wr_row] <= |req.wr_word;
            end
            if (req.rd_en)
            begin
                row_valid_reg <= summary_reg[rd_row];
            end
        end
    end

    assign rsp.word    = row_valid_reg ? word_q_reg : '0;
    assign rsp.head    = slot_q_reg[2*SLOT_W-1:SLOT_W];
    assign rsp.tail    = slot_q_reg[SLOT_W-1:0];
    assign rsp.summary = summary_reg;

    // A row write and a row read never hit the same row in one cycle
    a_no_row_collision: assert property (@(posedge clk) disable iff (!rst_n)
        (req.wr_en && req.rd_en) |-> (wr_row != rd_row))
        else $error("row read and write collide");

    // The summary flop follows the data written to its row
    a_summary_tracks: assert property (@(posedge clk) disable iff (!rst_n)
        req.wr_en |=> (summary_reg[$past(wr_row)] == (|$past(req.wr_word))))
        else $error("row summary out of step");

    // A valid row read never returns an empty row
    a_valid_row_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        row_valid_reg |-> (word_q_reg != '0))
        else $error("valid row reads empty");

endmodule

`default_nettype wire

@@ design/order_book_price_level_tracker.sv @@
// ============================================================================
// order_book_price_level_tracker
// One side of an order book: price levels with active flag and head/tail
// order slots, plus the best price of the side.
// ============================================================================
// Usage:
//   req carries one item (kind, price, order_index); rsp returns exactly one
//   result item per request, in order. Items are accepted only while the
//   controller is idle.
//   Sequence: an accepted item passes S_CHECK, S_MODIFY and S_DONE, then
//   the output register; a price outside the range goes from S_CHECK to
//   S_DONE, and deactivating the best level adds S_SCAN for a second bitmap
//   row read. A new item is taken only after the last one has left S_DONE;
//   each item reads and writes the level store through its read and write
//   ports, and the best search walks a per-row summary, then one bitmap
//   row.
//   The result waits in an output register; while the receiver stalls the
//   next item is still accepted and processed up to its final step, where
//   it waits until the output register is free.
//   Reset clears the bitmap at once through the per-row summary flops, so
//   no clearing pass is needed; registers return to bid side, min price 0,
//   1024 levels. Configuration (cfg_we/cfg_index/cfg_data) may be written
//   only while no item is in flight.
// ============================================================================
`default_nettype none

module order_book_price_level_tracker
    import obpl_pkg::*;
(
    input  wire                  clk,
    input  wire                  rst_n,
    input  wire                  cfg_we,
    input  wire [CFG_IDX_W-1:0]  cfg_index,
    input  wire [CFG_DATA_W-1:0] cfg_data,
    obpl_req_if.sink             req,
    obpl_rsp_if.source           rsp
);

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_CHECK  = 5'b00010,
        S_MODIFY = 5'b00100,
        S_SCAN   = 5'b01000,
        S_DONE   = 5'b10000
    } state_t;

    state_t state_reg, state_next;

    // Registers
    logic                  is_bid_reg;
    logic [PRICE_W-1:0]    min_price_reg;
    logic [CNT_W-1:0]      level_count_reg;

    // Item in flight
    logic [KIND_W-1:0]     kind_reg;
    logic [SLOT_W-1:0]     slot_reg;
    logic [PRICE_W:0]      off_reg, off_next;

    // Best level
    logic [IDX_W-1:0]      best_index_reg, best_index_next;
    logic                  best_present_reg, best_present_next;
    logic [ROW_W-1:0]      scan_row_reg, scan_row_next;

    // Per-level result
    logic                  res_status_reg, res_status_next;
    logic                  res_active_reg, res_active_next;
    logic [HEAD_W-1:0]     res_head_reg, res_head_next;
    logic [HEAD_W-1:0]     res_tail_reg, res_tail_next;

    // Output register
    logic                  out_valid_reg, out_valid_next;
    logic                  out_status_reg;
    logic                  out_active_reg;
    logic [HEAD_W-1:0]     out_head_reg;
    logic [HEAD_W-1:0]     out_tail_reg;
    logic                  out_best_valid_reg;
    logic [PRICE_W-1:0]    out_best_price_reg;

    store_req_t            st_req;
    store_rsp_t            st_rsp;

    logic                  accept;
    logic                  out_free;
    logic                  load_out;
    logic [USED_W-1:0]     used_lv;
    logic                  in_range;
    logic [IDX_W-1:0]      idx;
    logic [ROW_W-1:0]      cur_row;
    logic [COL_W-1:0]      cur_col;
    logic [WORD_W-1:0]     bit_sel;
    logic [WORD_W-1:0]     below_col;
    logic [WORD_W-1:0]     above_col;
    logic [ROWS-1:0]       below_row;
    logic [ROWS-1:0]       above_row;
    hit_t                  word_hit;
    hit_t                  row_hit;
    hit_t                  scan_hit;
    logic [IDX_W-1:0]      cand_mod;
    logic [IDX_W-1:0]      cand_scan;

    obpl_level_store u_store (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (st_req),
        .rsp   (st_rsp)
    );

    assign accept   = req.valid && req.ready;
    assign req.ready = (state_reg == S_IDLE);
    assign out_free = !out_valid_reg || rsp.ready;
    assign load_out = (state_reg == S_DONE) && out_free;

    // Clamp the level count to 1..LEVELS
    always_comb
    begin
        if (level_count_reg == '0)
        begin
            used_lv = USED_W'(1);
        end
        else if (32'(level_count_reg) >= LEVELS)
        begin
            used_lv = USED_W'(LEVELS);
        end
        else
        begin
            used_lv = USED_W'(level_count_reg);
        end
    end

    assign in_range = !off_reg[PRICE_W] && (off_reg[PRICE_W-1:0] < 32'(used_lv));
    assign idx      = off_reg[IDX_W-1:0];
    assign cur_row  = idx[IDX_W-1:COL_W];
    assign cur_col  = idx[COL_W-1:0];
    assign bit_sel  = WORD_W'(1) << cur_col;

    // Search masks toward worse prices
    always_comb
    begin
        for (int j = 0; j < WORD_W; j++)
        begin
            below_col[j] = (COL_W'(j) < cur_col);
            above_col[j] = (COL_W'(j) > cur_col);
        end
        for (int j = 0; j < ROWS; j++)
        begin
            below_row[j] = (ROW_W'(j) < cur_row);
            above_row[j] = (ROW_W'(j) > cur_row);
        end
    end

    // Priority encoders: within the addressed row, over the summary, and
    // within the row fetched for the scan
    always_comb
    begin
        if (is_bid_reg)
        begin
            word_hit = find_high(SCAN_W'(st_rsp.word & below_col));
            row_hit  = find_high(SCAN_W'(st_rsp.summary & below_row));
            scan_hit = find_high(SCAN_W'(st_rsp.word));
        end
        else
        begin
            word_hit = find_low(SCAN_W'(st_rsp.word & above_col));
            row_hit  = find_low(SCAN_W'(st_rsp.summary & above_row));
            scan_hit = find_low(SCAN_W'(st_rsp.word));
        end
    end

    assign cand_mod  = {cur_row, COL_W'(word_hit.pos)};
    assign cand_scan = {scan_row_reg, COL_W'(scan_hit.pos)};

    // Controller
    always_comb
    begin
        state_next        = state_reg;
        off_next          = off_reg;
        best_index_next   = best_index_reg;
        best_present_next = best_present_reg;
        scan_row_next     = scan_row_reg;
        res_status_next   = res_status_reg;
        res_active_next   = res_active_reg;
        res_head_next     = res_head_reg;
        res_tail_next     = res_tail_reg;
        st_req            = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    off_next   = {req.price[PRICE_W-1], req.price}
                               - {min_price_reg[PRICE_W-1], min_price_reg};
                    state_next = S_CHECK;
                end
            end

            S_CHECK:
            begin
                if (in_range)
                begin
                    st_req.rd_en  = 1'b1;
                    st_req.rd_idx = idx;
                    state_next    = S_MODIFY;
                end
                else
                begin
                    res_status_next = 1'b1;
                    res_active_next = 1'b0;
                    res_head_next   = '0;
                    res_tail_next   = '0;
                    state_next      = S_DONE;
                end
            end

            S_MODIFY:
            begin
                res_status_next = 1'b0;
                state_next      = S_DONE;
                unique case (kind_reg)
                    KIND_ACTIVATE:
                    begin
                        st_req.wr_en      = 1'b1;
                        st_req.wr_idx     = idx;
                        st_req.wr_word    = st_rsp.word | bit_sel;
                        st_req.wr_slot_en = 1'b1;
                        st_req.wr_slot    = slot_reg;
                        res_active_next   = 1'b1;
                        res_head_next     = HEAD_W'(slot_reg);
                        res_tail_next     = HEAD_W'(slot_reg);
                        if (!best_present_reg
                            || (is_bid_reg && (idx > best_index_reg))
                            || (!is_bid_reg && (idx < best_index_reg)))
                        begin
                            best_present_next = 1'b1;
                            best_index_next   = idx;
                        end
                    end

                    KIND_DEACTIVATE:
                    begin
                        st_req.wr_en    = 1'b1;
                        st_req.wr_idx   = idx;
                        st_req.wr_word  = st_rsp.word & ~bit_sel;
                        res_active_next = 1'b0;
                        res_head_next   = ORDER_SLOTS;
                        res_tail_next   = ORDER_SLOTS;
                        if (best_present_reg && (idx == best_index_reg))
                        begin
                            if (word_hit.found)
                            begin
                                // Next level sits in the same row
                                if (is_bid_reg || (USED_W'(cand_mod) < used_lv))
                                begin
                                    best_index_next = cand_mod;
                                end
                                else
                                begin
                                    best_present_next = 1'b0;
                                    best_index_next   = '0;
                                end
                            end
                            else if (row_hit.found)
                            begin
                                // Fetch the nearest non-empty row
                                scan_row_next = ROW_W'(row_hit.pos);
                                st_req.rd_en  = 1'b1;
                                st_req.rd_idx = {ROW_W'(row_hit.pos), COL_W'(0)};
                                state_next    = S_SCAN;
                            end
                            else
                            begin
                                best_present_next = 1'b0;
                                best_index_next   = '0;
                            end
                        end
                    end

                    default:
                    begin
                        res_active_next = st_rsp.word[cur_col];
                        res_head_next   = st_rsp.word[cur_col]
                                        ? HEAD_W'(st_rsp.head) : ORDER_SLOTS;
                        res_tail_next   = st_rsp.word[cur_col]
                                        ? HEAD_W'(st_rsp.tail) : ORDER_SLOTS;
                    end
                endcase
            end

            S_SCAN:
            begin
                if (scan_hit.found
                    && (is_bid_reg || (USED_W'(cand_scan) < used_lv)))
                begin
                    best_index_next = cand_scan;
                end
                else
                begin
                    best_present_next = 1'b0;
                    best_index_next   = '0;
                end
                state_next = S_DONE;
            end

            S_DONE:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Output handshake
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            best_index_reg   <= '0;
            best_present_reg <= 1'b0;
            out_valid_reg    <= 1'b0;
            is_bid_reg       <= 1'b1;
            min_price_reg    <= '0;
            level_count_reg  <= CNT_W'(1024);
        end
        else
        begin
            state_reg        <= state_next;
            best_index_reg   <= best_index_next;
            best_present_reg <= best_present_next;
            out_valid_reg    <= out_valid_next;
            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_IS_BID:      is_bid_reg      <= cfg_data[0];
                    CFG_MIN_PRICE:   min_price_reg   <= cfg_data[PRICE_W-1:0];
                    CFG_LEVEL_COUNT: level_count_reg <= cfg_data[CNT_W-1:0];
                    default:         ;
                endcase
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        off_reg        <= off_next;
        scan_row_reg   <= scan_row_next;
        res_status_reg <= res_status_next;
        res_active_reg <= res_active_next;
        res_head_reg   <= res_head_next;
        res_tail_reg   <= res_tail_next;
        if (accept)
        begin
            kind_reg <= req.kind;
            slot_reg <= req.order_index;
        end
        if (load_out)
        begin
            out_status_reg     <= res_status_reg;
            out_active_reg     <= res_active_reg;
            out_head_reg       <= res_head_reg;
            out_tail_reg       <= res_tail_reg;
            out_best_valid_reg <= best_present_reg;
            out_best_price_reg <= best_present_reg
                                ? (min_price_reg + PRICE_W'(best_index_reg)) : '0;
        end
    end

    assign rsp.valid        = out_valid_reg;
    assign rsp.status       = out_status_reg;
    assign rsp.level_active = out_active_reg;
    assign rsp.level_head   = out_head_reg;
    assign rsp.level_tail   = out_tail_reg;
    assign rsp.best_valid   = out_best_valid_reg;
    assign rsp.best_price   = out_best_price_reg;

    // An empty side always reports best index zero
    a_empty_best_zero: assert property (@(posedge clk) disable iff (!rst_n)
        !best_present_reg |-> (best_index_reg == '0))
        else $error("empty side with nonzero best index");

    // The row scan only follows a read-modify-write step
    a_scan_after_modify: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCAN) |-> ($past(state_reg) == S_MODIFY))
        else $error("row scan entered out of order");

    // Writes to the level store happen only in the modify step
    a_write_in_modify: assert property (@(posedge clk) disable iff (!rst_n)
        st_req.wr_en |-> (state_reg == S_MODIFY))
        else $error("level store written outside modify step");

    // An accepted item always goes to the range check next
    a_accept_to_check: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg == S_CHECK))
        else $error("accepted item skipped range check");

endmodule

`default_nettype wire
